// ===== hdl/alir_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package alir_pkg;

    localparam int DEPTH  = 64;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int POS_W  = 6;
    localparam int ACT_W  = 3;
    localparam int CMP_W  = POS_W + 1;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [CNT_W-1:0]         t_cnt;

    localparam logic [ACT_W-1:0] ACT_APPEND     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_OVERWRITE  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE_END = 3'd2;
    localparam logic [ACT_W-1:0] ACT_REMOVE_AT  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_READ_ALL   = 3'd4;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        t_word            value;
        logic [POS_W-1:0] position;
    } t_cmd;

    typedef struct packed {
        t_status          status;
        t_word            item_value;
        logic [POS_W-1:0] item_position;
        logic             last;
    } t_result;

    // Broadcast from the controller to every cell of the chain.
    typedef struct packed {
        logic  write_en;
        t_idx  write_idx;
        t_word value;
        logic  shift_en;
        t_idx  shift_lo;
        t_cnt  fill;
        logic  tap_load;
        logic  tap_shift;
    } t_cell_ctl;

endpackage
`default_nettype wire

// ===== hdl/array_list_insert_remove.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Append, overwrite and error results: in the cycle after the transfer; busy stays low.
// Remove at position p (remove last: p = fill-1): busy while the tap chain, moving one cell
//   toward cell 0 per cycle, walks entry p of the snapshot down to cell 0; its result is then registered.
// Read all of n entries: n results, one per cycle, registered from cell 0's tap while the
//   chain walks and busy is high. Results cannot be stalled by the receiver.
// Reset (synchronous, i_rst_n low) clears the fill count, controller state and strobe.
module array_list_insert_remove (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    input  alir_pkg::t_cmd     i_cmd,
    output logic               busy,
    output logic               o_strobe,
    output alir_pkg::t_result  o_result
);
    import alir_pkg::*;

    // One cell per list slot. Each cell keeps its word and a tap register; the
    // taps form a chain that hands a snapshot of the list down to cell 0.
    t_cell_ctl w_ctl;
    t_word     w_word [DEPTH];
    t_word     w_tap [DEPTH];
    t_word     w_upper_word [DEPTH];
    t_word     w_upper_tap [DEPTH];

    alir_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .i_tap0   (w_tap[0]),
        .busy     (busy),
        .o_ctl    (w_ctl),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        // Top cell has no upper neighbor; its upper word is never selected, and its tap takes in zero on a shift.
        if (g == DEPTH - 1) begin : g_top
            assign w_upper_word[g] = '0;
            assign w_upper_tap[g]  = '0;
        end else begin : g_mid
            assign w_upper_word[g] = w_word[g+1];
            assign w_upper_tap[g]  = w_tap[g+1];
        end

        alir_cell u_cell (
            .i_clk        (i_clk),
            .i_index      (IDX_W'(g)),
            .i_ctl        (w_ctl),
            .i_upper_word (w_upper_word[g]),
            .i_upper_tap  (w_upper_tap[g]),
            .o_word       (w_word[g]),
            .o_tap        (w_tap[g])
        );
    end

endmodule
`default_nettype wire

// ===== hdl/alir_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module alir_cell (
    input  wire                 i_clk,
    input  alir_pkg::t_idx      i_index,
    input  alir_pkg::t_cell_ctl i_ctl,
    input  alir_pkg::t_word     i_upper_word,
    input  alir_pkg::t_word     i_upper_tap,
    output alir_pkg::t_word     o_word,
    output alir_pkg::t_word     o_tap
);
    import alir_pkg::*;

    t_word r_word;
    t_word n_word;
    t_word r_tap;
    t_word n_tap;
    logic  w_shift_hit;

    // Close the gap: this cell lies at or above the removed slot and below the last entry.
    assign w_shift_hit = i_ctl.shift_en && (i_index >= i_ctl.shift_lo)
                         && ((CNT_W'(i_index) + CNT_W'(1)) < i_ctl.fill);

    always_comb begin
        n_word = r_word;
        if (i_ctl.write_en && (i_index == i_ctl.write_idx)) begin
            n_word = i_ctl.value;
        end else if (w_shift_hit) begin
            n_word = i_upper_word;
        end
    end

    // Tap chain: snapshot of the words, walked down toward cell 0.
    always_comb begin
        n_tap = r_tap;
        if (i_ctl.tap_load) begin
            n_tap = r_word;
        end else if (i_ctl.tap_shift) begin
            n_tap = i_upper_tap;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_tap  <= n_tap;
    end

    assign o_word = r_word;
    assign o_tap  = r_tap;

endmodule
`default_nettype wire

// ===== hdl/alir_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module alir_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    input  alir_pkg::t_cmd      i_cmd,
    input  alir_pkg::t_word     i_tap0,
    output logic                busy,
    output alir_pkg::t_cell_ctl o_ctl,
    output logic                o_strobe,
    output alir_pkg::t_result   o_result
);
    import alir_pkg::*;

    typedef enum logic {S_IDLE, S_WALK} t_state;

    t_state  r_state;
    t_state  n_state;
    t_cnt    r_fill;
    t_cnt    n_fill;
    t_idx    r_idx;
    t_idx    n_idx;
    t_idx    r_end;
    t_idx    n_end;
    logic    r_single;
    logic    n_single;
    logic    r_strobe;
    logic    n_strobe;
    t_result r_out;
    t_result n_out;

    logic    w_accept;
    logic    w_pos_ok;
    logic    w_full;
    logic    w_empty;
    t_idx    w_pos_idx;
    t_idx    w_fill_idx;
    t_cnt    w_fill_m1;

    assign w_accept   = start && (r_state == S_IDLE);
    assign w_pos_ok   = CMP_W'(i_cmd.position) < CMP_W'(r_fill);
    assign w_full     = (r_fill == CNT_W'(DEPTH));
    assign w_empty    = (r_fill == '0);
    assign w_pos_idx  = i_cmd.position[IDX_W-1:0];
    assign w_fill_idx = r_fill[IDX_W-1:0];
    assign w_fill_m1  = r_fill - CNT_W'(1);

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_idx    = r_idx;
        n_end    = r_end;
        n_single = r_single;
        n_strobe = 1'b0;
        n_out    = r_out;

        o_ctl           = '0;
        o_ctl.value     = i_cmd.value;
        o_ctl.fill      = r_fill;
        o_ctl.shift_lo  = w_pos_idx;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out.last = 1'b1;
                    case (i_cmd.action)
                        ACT_APPEND: begin
                            n_strobe            = 1'b1;
                            n_out.item_value    = i_cmd.value;
                            if (w_full) begin
                                n_out.status        = ST_FULL;
                                n_out.item_position = '0;
                            end else begin
                                o_ctl.write_en      = 1'b1;
                                o_ctl.write_idx     = w_fill_idx;
                                n_out.status        = ST_OK;
                                n_out.item_position = POS_W'(r_fill);
                                n_fill              = r_fill + CNT_W'(1);
                            end
                        end
                        ACT_OVERWRITE: begin
                            n_strobe            = 1'b1;
                            n_out.item_value    = i_cmd.value;
                            n_out.item_position = i_cmd.position;
                            if (w_pos_ok) begin
                                o_ctl.write_en  = 1'b1;
                                o_ctl.write_idx = w_pos_idx;
                                n_out.status    = ST_OK;
                            end else begin
                                n_out.status    = ST_INVALID;
                            end
                        end
                        ACT_REMOVE_END: begin
                            if (w_empty) begin
                                n_strobe            = 1'b1;
                                n_out.status        = ST_EMPTY;
                                n_out.item_value    = '0;
                                n_out.item_position = '0;
                            end else begin
                                o_ctl.tap_load = 1'b1;
                                n_fill         = w_fill_m1;
                                n_idx          = '0;
                                n_end          = w_fill_m1[IDX_W-1:0];
                                n_single       = 1'b1;
                                n_state        = S_WALK;
                            end
                        end
                        ACT_REMOVE_AT: begin
                            if (w_pos_ok) begin
                                o_ctl.tap_load = 1'b1;
                                o_ctl.shift_en = 1'b1;
                                n_fill         = w_fill_m1;
                                n_idx          = '0;
                                n_end          = w_pos_idx;
                                n_single       = 1'b1;
                                n_state        = S_WALK;
                            end else begin
                                n_strobe            = 1'b1;
                                n_out.status        = ST_INVALID;
                                n_out.item_value    = '0;
                                n_out.item_position = i_cmd.position;
                            end
                        end
                        ACT_READ_ALL: begin
                            if (w_empty) begin
                                n_strobe            = 1'b1;
                                n_out.status        = ST_EMPTY;
                                n_out.item_value    = '0;
                                n_out.item_position = '0;
                            end else begin
                                o_ctl.tap_load = 1'b1;
                                n_idx          = '0;
                                n_end          = w_fill_m1[IDX_W-1:0];
                                n_single       = 1'b0;
                                n_state        = S_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WALK: begin
                // Cell 0's tap holds entry r_idx of the snapshot.
                if (!r_single || (r_idx == r_end)) begin
                    n_strobe            = 1'b1;
                    n_out.status        = ST_OK;
                    n_out.item_value    = i_tap0;
                    n_out.item_position = POS_W'(r_idx);
                    n_out.last          = (r_idx == r_end);
                end
                if (r_idx == r_end) begin
                    n_state = S_IDLE;
                end else begin
                    o_ctl.tap_shift = 1'b1;
                    n_idx           = r_idx + IDX_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_strobe <= n_strobe;
        end
        r_idx    <= n_idx;
        r_end    <= n_end;
        r_single <= n_single;
        r_out    <= n_out;
    end

    assign busy     = (r_state == S_WALK);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_idx <= r_end))
        else $error("walk index passed its end");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && ((i_cmd.action == ACT_APPEND) || (i_cmd.action == ACT_OVERWRITE)))
        |=> (r_strobe && r_out.last))
        else $error("append or overwrite gave no result");

    a_partial_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && !r_out.last) |-> (r_state == S_WALK))
        else $error("non-final result outside read-out");

    a_idle_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) && r_strobe) |-> r_out.last)
        else $error("idle result not marked last");

endmodule
`default_nettype wire
